@@ src/catmull_rom_resampler_core_assert.svh @@
// assertion macros shared by the resampler modules
// every property is sampled on clk and switched off while rst_n is low
`ifndef CATMULL_ROM_RESAMPLER_CORE_ASSERT_SVH
`define CATMULL_ROM_RESAMPLER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define CRR_ASSERT_ALWAYS(name, expr) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("resampler assertion failed");

`define CRR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("resampler assertion failed");

`define CRR_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler assertion failed");

`else

`define CRR_ASSERT_ALWAYS(name, expr)
`define CRR_ASSERT_IMP(name, ante, cons)
`define CRR_ASSERT_NEXT(name, ante, cons)

`endif

`endif

@@ src/crr_pkg.sv @@
package crr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int FRAC_BITS   = 16;
  localparam int WIN_DEPTH   = 6;
  localparam int MAX_OUT     = 48;

  // phase spans -32 .. just under +32 samples
  localparam int PHASE_BITS = FRAC_BITS + 6;
  localparam int INT_BITS   = PHASE_BITS - FRAC_BITS;
  localparam int STEP_BITS  = FRAC_BITS + 5;
  // cubic coefficients and horner partial sums stay below 24 full scales
  localparam int COEF_BITS  = SAMPLE_BITS + 6;
  localparam int PROD_BITS  = COEF_BITS + FRAC_BITS + 1;
  localparam int CNT_BITS   = $clog2(MAX_OUT + 1);

  localparam logic [STEP_BITS-1:0] STEP_RESET = STEP_BITS'(1 << FRAC_BITS);

  localparam logic signed [PHASE_BITS-1:0] PHASE_ONE   = PHASE_BITS'(1 << FRAC_BITS);
  localparam logic signed [PHASE_BITS-1:0] PHASE_M_ONE = PHASE_BITS'(-(1 << FRAC_BITS));
  localparam logic signed [PHASE_BITS-1:0] PHASE_MIN   = PHASE_BITS'(-4 * (1 << FRAC_BITS));

  // integer part of the phase while a run is active
  localparam logic [INT_BITS-1:0] INT_M4 = INT_BITS'(-4);
  localparam logic [INT_BITS-1:0] INT_M3 = INT_BITS'(-3);

  localparam logic [CNT_BITS-1:0] CNT_MAX = CNT_BITS'(MAX_OUT);

  localparam logic signed [PROD_BITS-1:0] ROUND_HALF = PROD_BITS'(1 << (FRAC_BITS - 1));
  localparam logic signed [COEF_BITS-1:0] COEF_ONE   = COEF_BITS'(1);
  localparam logic signed [COEF_BITS-1:0] SAT_HI =
    COEF_BITS'((longint'(1) <<< (SAMPLE_BITS - 1)) - longint'(1));
  localparam logic signed [COEF_BITS-1:0] SAT_LO =
    COEF_BITS'(-(longint'(1) <<< (SAMPLE_BITS - 1)));

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LOAD,
    ST_MUL_C,
    ST_ADD_U,
    ST_MUL_U,
    ST_ADD_W,
    ST_MUL_W,
    ST_ADD_Y,
    ST_PRESENT
  } crr_state_t;

  typedef enum logic [0:0] {
    MUL_C,
    MUL_ACC
  } crr_mul_t;

  typedef enum logic [1:0] {
    ACC_U,
    ACC_W,
    ACC_Y
  } crr_acc_t;

  typedef struct packed {
    logic     shift;
    logic     clr_cnt;
    logic     load_coef;
    logic     mul_en;
    crr_mul_t mul_src;
    logic     acc_en;
    crr_acc_t acc_op;
    logic     present;
    logic     drop;
  } crr_cmd_t;

  typedef struct packed {
    logic more;
    logic out_free;
  } crr_stat_t;

endpackage

@@ src/catmull_rom_resampler_core.sv @@
// a request runs a check step, then for each of its n results (n up to 48) a load step,
//   c*t, u, u*t, w, w*t, y and a present step, the single shared multiplier being used
//   three times per cubic; no new request is taken before the run ends
// a stalled result holds the sequencer in its present step until taken
// reset (rst_n low, synchronous): window cleared, phase -4.0, step 1.0, no result pending
module catmull_rom_resampler_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // request side
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [crr_pkg::SAMPLE_BITS-1:0] in_sample_in,
  // step register, unsigned q.16 advance per result
  input  logic                                   cfg_we,
  input  logic        [crr_pkg::STEP_BITS-1:0]   cfg_phase_step,
  // result side
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [crr_pkg::SAMPLE_BITS-1:0] out_sample_out,
  output logic                                   out_last_of_run
);

  // the controller walks each result through
  //   load taps and coefficients -> c*t -> u -> u*t -> w -> w*t -> y -> present
  // and decides after every result whether the run goes on; the datapath
  // holds the delay line, the phase, the shared multiplier and the output register
  crr_pkg::crr_cmd_t  cmd;
  crr_pkg::crr_stat_t stat;

  crr_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // output register parts the sequencer from the result side, so a new
  // request is taken while the final result of the last run still waits
  crr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_sample_in    (in_sample_in),
    .cfg_we          (cfg_we),
    .cfg_phase_step  (cfg_phase_step),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_sample_out  (out_sample_out),
    .out_last_of_run (out_last_of_run)
  );

endmodule

@@ src/crr_datapath.sv @@
`include "catmull_rom_resampler_core_assert.svh"

module crr_datapath (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  crr_pkg::crr_cmd_t                        cmd,
  output crr_pkg::crr_stat_t                       stat,
  input  logic signed [crr_pkg::SAMPLE_BITS-1:0]   in_sample_in,
  input  logic                                     cfg_we,
  input  logic        [crr_pkg::STEP_BITS-1:0]     cfg_phase_step,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output logic signed [crr_pkg::SAMPLE_BITS-1:0]   out_sample_out,
  output logic                                     out_last_of_run
);

  logic signed [crr_pkg::SAMPLE_BITS-1:0] win_r [crr_pkg::WIN_DEPTH];
  logic        [crr_pkg::STEP_BITS-1:0]   step_r;
  logic signed [crr_pkg::PHASE_BITS-1:0]  phase_r;
  logic signed [crr_pkg::PHASE_BITS-1:0]  phase_nxt;
  logic signed [crr_pkg::PHASE_BITS-1:0]  phase_sum;
  logic signed [crr_pkg::PHASE_BITS-1:0]  phase_dec;
  logic        [crr_pkg::CNT_BITS-1:0]    cnt_r;
  logic        [crr_pkg::CNT_BITS-1:0]    cnt_nxt;

  logic signed [crr_pkg::SAMPLE_BITS-1:0] p0, p1, p2, p3;
  logic signed [crr_pkg::COEF_BITS-1:0]   q0, q1, q2, q3;
  logic signed [crr_pkg::COEF_BITS-1:0]   a_nxt, b_nxt, c_nxt;
  logic signed [crr_pkg::COEF_BITS-1:0]   a_r, b_r, c_r, p1_r;
  logic signed [crr_pkg::COEF_BITS-1:0]   acc_r;
  logic signed [crr_pkg::COEF_BITS-1:0]   acc_nxt;

  logic signed [crr_pkg::COEF_BITS-1:0]   mul_a;
  logic signed [crr_pkg::FRAC_BITS:0]     t_s;
  logic signed [crr_pkg::PROD_BITS-1:0]   prod_full;
  logic signed [crr_pkg::PROD_BITS-1:0]   prod_r;
  logic signed [crr_pkg::PROD_BITS-1:0]   rnd_full;
  logic signed [crr_pkg::COEF_BITS-1:0]   rnd;
  logic signed [crr_pkg::COEF_BITS-1:0]   y2;
  logic signed [crr_pkg::COEF_BITS-1:0]   y_half;
  logic signed [crr_pkg::SAMPLE_BITS-1:0] y_sat;
  logic signed [crr_pkg::SAMPLE_BITS-1:0] y_r;

  logic                                   out_valid_r;
  logic                                   out_valid_nxt;
  logic signed [crr_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic                                   out_last_r;

  logic y_step;

  assign y_step = cmd.acc_en && (cmd.acc_op == crr_pkg::ACC_Y);

  // four neighbours around floor(phase), taken from fixed taps
  always_comb begin
    case (phase_r[crr_pkg::PHASE_BITS-1:crr_pkg::FRAC_BITS])
      crr_pkg::INT_M4: begin
        p0 = win_r[5];
        p1 = win_r[4];
        p2 = win_r[3];
        p3 = win_r[2];
      end
      crr_pkg::INT_M3: begin
        p0 = win_r[4];
        p1 = win_r[3];
        p2 = win_r[2];
        p3 = win_r[1];
      end
      default: begin
        p0 = win_r[3];
        p1 = win_r[2];
        p2 = win_r[1];
        p3 = win_r[0];
      end
    endcase
  end

  always_comb begin
    q0 = crr_pkg::COEF_BITS'(p0);
    q1 = crr_pkg::COEF_BITS'(p1);
    q2 = crr_pkg::COEF_BITS'(p2);
    q3 = crr_pkg::COEF_BITS'(p3);
    a_nxt = q2 - q0;
    b_nxt = (q0 <<< 1) - (q1 <<< 2) - q1 + (q2 <<< 2) - q3;
    c_nxt = (q1 <<< 1) + q1 - (q2 <<< 1) - q2 + q3 - q0;
  end

  // shared multiplier, fraction of the phase as t
  assign t_s       = {1'b0, phase_r[crr_pkg::FRAC_BITS-1:0]};
  assign mul_a     = (cmd.mul_src == crr_pkg::MUL_C) ? c_r : acc_r;
  assign prod_full = mul_a * t_s;

  always_comb begin
    rnd_full = (prod_r + crr_pkg::ROUND_HALF) >>> crr_pkg::FRAC_BITS;
    rnd      = rnd_full[crr_pkg::COEF_BITS-1:0];
    y2       = (p1_r <<< 1) + rnd;
    y_half   = (y2 + crr_pkg::COEF_ONE) >>> 1;
    if (y_half > crr_pkg::SAT_HI) begin
      y_sat = crr_pkg::SAT_HI[crr_pkg::SAMPLE_BITS-1:0];
    end else if (y_half < crr_pkg::SAT_LO) begin
      y_sat = crr_pkg::SAT_LO[crr_pkg::SAMPLE_BITS-1:0];
    end else begin
      y_sat = y_half[crr_pkg::SAMPLE_BITS-1:0];
    end
    case (cmd.acc_op)
      crr_pkg::ACC_U: acc_nxt = b_r + rnd;
      crr_pkg::ACC_W: acc_nxt = a_r + rnd;
      default:        acc_nxt = acc_r;
    endcase
  end

  always_comb begin
    phase_sum = phase_r + $signed({1'b0, step_r});
    phase_dec = phase_r - crr_pkg::PHASE_ONE;
    phase_nxt = phase_r;
    if (y_step) begin
      phase_nxt = phase_sum;
    end else if (cmd.drop) begin
      phase_nxt = (phase_dec < crr_pkg::PHASE_MIN) ? crr_pkg::PHASE_MIN : phase_dec;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.clr_cnt) begin
      cnt_nxt = '0;
    end else if (y_step) begin
      cnt_nxt = crr_pkg::CNT_BITS'(cnt_r + 1'b1);
    end
  end

  always_comb begin
    stat.more     = (phase_r < crr_pkg::PHASE_M_ONE) && (cnt_r < crr_pkg::CNT_MAX);
    stat.out_free = !out_valid_r || !out_stall;
  end

  always_comb begin
    if (cmd.present) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < crr_pkg::WIN_DEPTH; k++) begin
        win_r[k] <= '0;
      end
      step_r      <= crr_pkg::STEP_RESET;
      phase_r     <= crr_pkg::PHASE_MIN;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.shift) begin
        for (int k = crr_pkg::WIN_DEPTH - 1; k > 0; k--) begin
          win_r[k] <= win_r[k-1];
        end
        win_r[0] <= in_sample_in;
      end
      if (cfg_we) begin
        step_r <= cfg_phase_step;
      end
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_coef) begin
      a_r  <= a_nxt;
      b_r  <= b_nxt;
      c_r  <= c_nxt;
      p1_r <= q1;
    end
    if (cmd.mul_en) begin
      prod_r <= prod_full;
    end
    if (cmd.acc_en && !y_step) begin
      acc_r <= acc_nxt;
    end
    if (y_step) begin
      y_r <= y_sat;
    end
    if (cmd.present) begin
      out_sample_r <= y_r;
      out_last_r   <= !stat.more;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_sample_out  = out_sample_r;
  assign out_last_of_run = out_last_r;

  `CRR_ASSERT_ALWAYS(a_phase_floor, phase_r >= crr_pkg::PHASE_MIN)
  `CRR_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= crr_pkg::CNT_MAX)
  `CRR_ASSERT_IMP(a_present_free, cmd.present, stat.out_free)

endmodule

@@ src/crr_controller.sv @@
`include "catmull_rom_resampler_core_assert.svh"

module crr_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  crr_pkg::crr_stat_t stat,
  output crr_pkg::crr_cmd_t  cmd
);

  crr_pkg::crr_state_t state_r;
  crr_pkg::crr_state_t state_nxt;
  logic                accept;

  assign in_stall = !rst_n || (state_r != crr_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      crr_pkg::ST_IDLE:    if (accept) state_nxt = crr_pkg::ST_CHECK;
      crr_pkg::ST_CHECK:   state_nxt = stat.more ? crr_pkg::ST_LOAD : crr_pkg::ST_IDLE;
      crr_pkg::ST_LOAD:    state_nxt = crr_pkg::ST_MUL_C;
      crr_pkg::ST_MUL_C:   state_nxt = crr_pkg::ST_ADD_U;
      crr_pkg::ST_ADD_U:   state_nxt = crr_pkg::ST_MUL_U;
      crr_pkg::ST_MUL_U:   state_nxt = crr_pkg::ST_ADD_W;
      crr_pkg::ST_ADD_W:   state_nxt = crr_pkg::ST_MUL_W;
      crr_pkg::ST_MUL_W:   state_nxt = crr_pkg::ST_ADD_Y;
      crr_pkg::ST_ADD_Y:   state_nxt = crr_pkg::ST_PRESENT;
      crr_pkg::ST_PRESENT: begin
        if (stat.out_free) begin
          state_nxt = stat.more ? crr_pkg::ST_LOAD : crr_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = crr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_src = crr_pkg::MUL_C;
    cmd.acc_op  = crr_pkg::ACC_U;
    case (state_r)
      crr_pkg::ST_IDLE: begin
        cmd.shift   = accept;
        cmd.clr_cnt = accept;
      end
      crr_pkg::ST_CHECK: begin
        cmd.drop = !stat.more;
      end
      crr_pkg::ST_LOAD: begin
        cmd.load_coef = 1'b1;
      end
      crr_pkg::ST_MUL_C: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = crr_pkg::MUL_C;
      end
      crr_pkg::ST_ADD_U: begin
        cmd.acc_en = 1'b1;
        cmd.acc_op = crr_pkg::ACC_U;
      end
      crr_pkg::ST_MUL_U: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = crr_pkg::MUL_ACC;
      end
      crr_pkg::ST_ADD_W: begin
        cmd.acc_en = 1'b1;
        cmd.acc_op = crr_pkg::ACC_W;
      end
      crr_pkg::ST_MUL_W: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_src = crr_pkg::MUL_ACC;
      end
      crr_pkg::ST_ADD_Y: begin
        cmd.acc_en = 1'b1;
        cmd.acc_op = crr_pkg::ACC_Y;
      end
      crr_pkg::ST_PRESENT: begin
        cmd.present = stat.out_free;
        cmd.drop    = stat.out_free && !stat.more;
      end
      default: begin
        cmd.drop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= crr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CRR_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_r == crr_pkg::ST_CHECK)
  `CRR_ASSERT_NEXT(a_run_end_idle, cmd.present && !stat.more, state_r == crr_pkg::ST_IDLE)

endmodule
